[design/cdb_pkg.sv]
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types, constants and a pointer helper for the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_POP_BACK   = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_READ       = 3'd4;
   localparam logic [2:0] CMD_WRITE      = 3'd5;

   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STS_RANGE     = 2'd3;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [DATA_W-1:0] data_in;
      logic [2:0]        position;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] front_value;
      logic [DATA_W-1:0] back_value;
      logic [CNT_W-1:0]  fill_count;
      logic              is_empty;
      logic              is_full_flag;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PEEK,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic peek;
      logic load_rsp;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } stat_type;

   // (base + off) mod DEPTH, both operands below DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_W+1)'(DEPTH)) begin
         sum = sum - (PTR_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

[design/cdb_ctrl.sv]
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer: take a request, execute it, read back front/back, hand off.
// ----------------------------------------------------------------------------
module cdb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdb_pkg::stat_type stat,
   output cdb_pkg::ctrl_type ctrl
);

   cdb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cdb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.load_req = 1'b1;
               state_in      = cdb_pkg::ST_EXEC;
            end
         end
         cdb_pkg::ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = cdb_pkg::ST_PEEK;
         end
         cdb_pkg::ST_PEEK: begin
            ctrl.peek = 1'b1;
            state_in  = cdb_pkg::ST_DONE;
         end
         cdb_pkg::ST_DONE: begin
            // wait here until the output register can take the result
            if (stat.out_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = cdb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/cdb_dpath.sv]
// ----------------------------------------------------------------------------
// cdb_dpath
// Slot store, head pointer, element count and the output register.
// ----------------------------------------------------------------------------
module cdb_dpath (
   input  logic              clock,
   input  logic              reset,
   input  cdb_pkg::ctrl_type ctrl,
   output cdb_pkg::stat_type stat,
   input  cdb_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdb_pkg::rsp_type  rsp_payload
);

   logic [cdb_pkg::DATA_W-1:0] mem [cdb_pkg::DEPTH];

   cdb_pkg::req_type            req_ff;
   logic [cdb_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [cdb_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [1:0]                  status_ff, status_in;
   logic                        read_ok_ff, read_ok_in;
   logic [cdb_pkg::DATA_W-1:0]  rd_a_ff, rd_b_ff, rdata_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   cdb_pkg::rsp_type            rsp_ff;

   logic                        wr_en;
   logic [cdb_pkg::PTR_W-1:0]   wr_addr;
   logic [cdb_pkg::PTR_W-1:0]   pos_addr;
   logic [cdb_pkg::PTR_W-1:0]   back_addr;
   logic [cdb_pkg::PTR_W-1:0]   head_dec;
   logic [cdb_pkg::PTR_W-1:0]   head_inc;
   logic                        full, empty, in_range;

   assign full     = (count_ff == cdb_pkg::CNT_W'(cdb_pkg::DEPTH));
   assign empty    = (count_ff == '0);
   assign in_range = (cdb_pkg::CNT_W'(req_ff.position) < count_ff);
   assign pos_addr = cdb_pkg::wrap_add(head_ff, cdb_pkg::PTR_W'(req_ff.position));
   assign back_addr = cdb_pkg::wrap_add(head_ff,
                                        cdb_pkg::PTR_W'(count_ff - cdb_pkg::CNT_W'(1)));
   assign head_dec = (head_ff == '0) ? cdb_pkg::PTR_W'(cdb_pkg::DEPTH - 1)
                                     : head_ff - cdb_pkg::PTR_W'(1);
   assign head_inc = (head_ff == cdb_pkg::PTR_W'(cdb_pkg::DEPTH - 1)) ? '0
                                     : head_ff + cdb_pkg::PTR_W'(1);

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      status_in  = cdb_pkg::STS_OK;
      read_ok_in = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_addr;
      unique case (req_ff.cmd)
         cdb_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               status_in = cdb_pkg::STS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cdb_pkg::wrap_add(head_ff, count_ff[cdb_pkg::PTR_W-1:0]);
               count_in = count_ff + cdb_pkg::CNT_W'(1);
            end
         end
         cdb_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = cdb_pkg::STS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + cdb_pkg::CNT_W'(1);
            end
         end
         cdb_pkg::CMD_POP_BACK: begin
            if (empty) begin
               status_in = cdb_pkg::STS_UNDERFLOW;
            end else begin
               count_in = count_ff - cdb_pkg::CNT_W'(1);
            end
         end
         cdb_pkg::CMD_POP_FRONT: begin
            if (empty) begin
               status_in = cdb_pkg::STS_UNDERFLOW;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - cdb_pkg::CNT_W'(1);
            end
         end
         cdb_pkg::CMD_READ: begin
            if (in_range) begin
               read_ok_in = 1'b1;
            end else begin
               status_in = cdb_pkg::STS_RANGE;
            end
         end
         cdb_pkg::CMD_WRITE: begin
            if (in_range) begin
               wr_en = 1'b1;
            end else begin
               status_in = cdb_pkg::STS_RANGE;
            end
         end
         default: begin
            // unused codes do nothing
         end
      endcase
   end

   assign rsp_valid_in  = ctrl.load_rsp | (rsp_valid_ff & rsp_stall);
   assign stat.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.exec) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // slot store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (ctrl.exec && wr_en) begin
         mem[wr_addr] <= req_ff.data_in;
      end
      if (ctrl.exec) begin
         rd_a_ff <= mem[pos_addr];
      end else if (ctrl.peek) begin
         rd_a_ff <= mem[head_ff];
         rd_b_ff <= mem[back_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         req_ff <= req_payload;
      end
      if (ctrl.exec) begin
         status_ff  <= status_in;
         read_ok_ff <= read_ok_in;
      end
      // rd_a still holds the positional read here
      if (ctrl.peek) begin
         rdata_ff <= read_ok_ff ? rd_a_ff : '0;
      end
      if (ctrl.load_rsp) begin
         rsp_ff.read_data    <= rdata_ff;
         rsp_ff.front_value  <= empty ? '0 : rd_a_ff;
         rsp_ff.back_value   <= empty ? '0 : rd_b_ff;
         rsp_ff.fill_count   <= count_ff;
         rsp_ff.is_empty     <= empty;
         rsp_ff.is_full_flag <= full;
         rsp_ff.status       <= status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[design/circular_deque_buffer.sv]
// One request at a time: a request is registered, executed, and the front/back
// readback runs on the slot store's two read ports before the response is loaded;
// a new request is taken only once that response has been loaded.
// Reset clears the head pointer, element count, sequencer and response valid;
// slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Double-ended ring buffer with push/pop at both ends and indexed read/write.
// ----------------------------------------------------------------------------
module circular_deque_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cdb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cdb_pkg::rsp_type rsp_payload
);

   cdb_pkg::ctrl_type ctrl;
   cdb_pkg::stat_type stat;

   cdb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   cdb_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // flags must agree with the count
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.fill_count == '0)) &&
                    (rsp_payload.is_full_flag ==
                     (rsp_payload.fill_count == cdb_pkg::CNT_W'(cdb_pkg::DEPTH))))
      else $error("empty/full flags disagree with fill count");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == cdb_pkg::STS_OVERFLOW |-> rsp_payload.is_full_flag)
      else $error("overflow reported while not full");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == cdb_pkg::STS_UNDERFLOW |-> rsp_payload.is_empty)
      else $error("underflow reported while not empty");

   // one request in flight: after taking one, stall until it is handed off
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another in flight");

endmodule

[sim/circular_deque_buffer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_buffer_test
// Drives push, pop, read, write and spare-code requests, some directed at
// the empty, full and out-of-range corners and the rest randomized in fill
// and drain phases. A scoreboard tracks the ring contents and checks every
// response field in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module circular_deque_buffer_test;

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int MAX_PRINTED     = 50;

   // Ring contents as seen from outside; one expected response per request.
   class deque_scoreboard;
      logic [cdb_pkg::DATA_W-1:0] slots [cdb_pkg::DEPTH];
      int head;
      int count;
      cdb_pkg::rsp_type expected_q [$];
      int mismatches;
      int responses;

      function new();
         head = 0;
         count = 0;
         mismatches = 0;
         responses = 0;
         foreach (slots[i]) slots[i] = '0;
      endfunction

      function int slot_at(int offset);
         return (head + offset) % cdb_pkg::DEPTH;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(cdb_pkg::req_type r);
         cdb_pkg::rsp_type e;
         e = '0;
         e.status = cdb_pkg::STS_OK;
         case (r.cmd)
            cdb_pkg::CMD_PUSH_BACK: begin
               if (count == cdb_pkg::DEPTH) begin
                  e.status = cdb_pkg::STS_OVERFLOW;
               end else begin
                  slots[slot_at(count)] = r.data_in;
                  count++;
               end
            end
            cdb_pkg::CMD_PUSH_FRONT: begin
               if (count == cdb_pkg::DEPTH) begin
                  e.status = cdb_pkg::STS_OVERFLOW;
               end else begin
                  head = (head + cdb_pkg::DEPTH - 1) % cdb_pkg::DEPTH;
                  slots[head] = r.data_in;
                  count++;
               end
            end
            cdb_pkg::CMD_POP_BACK: begin
               if (count == 0) begin
                  e.status = cdb_pkg::STS_UNDERFLOW;
               end else begin
                  count--;
               end
            end
            cdb_pkg::CMD_POP_FRONT: begin
               if (count == 0) begin
                  e.status = cdb_pkg::STS_UNDERFLOW;
               end else begin
                  head = (head + 1) % cdb_pkg::DEPTH;
                  count--;
               end
            end
            cdb_pkg::CMD_READ: begin
               if (int'(r.position) >= count) begin
                  e.status = cdb_pkg::STS_RANGE;
               end else begin
                  e.read_data = slots[slot_at(int'(r.position))];
               end
            end
            cdb_pkg::CMD_WRITE: begin
               if (int'(r.position) >= count) begin
                  e.status = cdb_pkg::STS_RANGE;
               end else begin
                  slots[slot_at(int'(r.position))] = r.data_in;
               end
            end
            default: ;
         endcase
         e.front_value  = (count != 0) ? slots[head] : '0;
         e.back_value   = (count != 0) ? slots[slot_at(count - 1)] : '0;
         e.fill_count   = cdb_pkg::CNT_W'(count);
         e.is_empty     = (count == 0);
         e.is_full_flag = (count == cdb_pkg::DEPTH);
         expected_q.insert(expected_q.size(), e);
      endfunction

      task report_mismatch(string what, logic [cdb_pkg::DATA_W-1:0] got,
                           logic [cdb_pkg::DATA_W-1:0] want);
         mismatches++;
         if (mismatches <= MAX_PRINTED) begin
            $display("ERROR response %0d: %s got %h expected %h", responses, what, got, want);
         end
      endtask

      task compare_field(string what, logic [cdb_pkg::DATA_W-1:0] got,
                         logic [cdb_pkg::DATA_W-1:0] want);
         if (got !== want) begin
            report_mismatch(what, got, want);
         end
      endtask

      task check_response(cdb_pkg::rsp_type got);
         cdb_pkg::rsp_type want;
         responses++;
         if (expected_q.size() == 0) begin
            report_mismatch("response with no request pending", '0, '0);
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         compare_field("read_data", got.read_data, want.read_data);
         compare_field("front_value", got.front_value, want.front_value);
         compare_field("back_value", got.back_value, want.back_value);
         compare_field("fill_count", cdb_pkg::DATA_W'(got.fill_count),
                       cdb_pkg::DATA_W'(want.fill_count));
         compare_field("is_empty", cdb_pkg::DATA_W'(got.is_empty),
                       cdb_pkg::DATA_W'(want.is_empty));
         compare_field("is_full_flag", cdb_pkg::DATA_W'(got.is_full_flag),
                       cdb_pkg::DATA_W'(want.is_full_flag));
         compare_field("status", cdb_pkg::DATA_W'(got.status),
                       cdb_pkg::DATA_W'(want.status));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_stall;
   cdb_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   cdb_pkg::rsp_type rsp_payload;

   deque_scoreboard sb;
   int  level;          // fill level implied by the requests issued so far
   int  send_quiet;
   int  idle_cycles;
   bit  squeeze;

   circular_deque_buffer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(cdb_pkg::req_type r);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (send_quiet > 0) begin
         gap = 0;
         send_quiet--;
      end else begin
         if ($urandom_range(0, 49) == 0) send_quiet = $urandom_range(20, 80);
         gap = idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(logic [2:0] cmd, logic [cdb_pkg::DATA_W-1:0] data, logic [2:0] pos);
      cdb_pkg::req_type r;
      r.cmd      = cmd;
      r.data_in  = data;
      r.position = pos;
      case (cmd) inside
         cdb_pkg::CMD_PUSH_BACK, cdb_pkg::CMD_PUSH_FRONT: begin
            if (level < cdb_pkg::DEPTH) level++;
         end
         cdb_pkg::CMD_POP_BACK, cdb_pkg::CMD_POP_FRONT: begin
            if (level > 0) level--;
         end
         default: ;
      endcase
      send_request(r);
   endtask

   task automatic run_directed();
      // refusals and no-ops on an empty deque
      issue(cdb_pkg::CMD_POP_BACK, '0, 3'd0);
      issue(cdb_pkg::CMD_POP_FRONT, '1, 3'd7);
      issue(cdb_pkg::CMD_READ, '0, 3'd0);
      issue(cdb_pkg::CMD_WRITE, '1, 3'd0);
      issue(CMD_SPARE_LO, 32'h5a5a_a5a5, 3'd5);
      issue(CMD_SPARE_HI, 32'ha5a5_5a5a, 3'd2);
      // push front from head zero wraps the head pointer
      issue(cdb_pkg::CMD_PUSH_BACK, '0, 3'd0);
      issue(cdb_pkg::CMD_PUSH_FRONT, '1, 3'd7);
      repeat (6) begin
         issue($urandom_range(0, 1) ? cdb_pkg::CMD_PUSH_FRONT : cdb_pkg::CMD_PUSH_BACK,
               $urandom, 3'd0);
      end
      // full
      issue(cdb_pkg::CMD_PUSH_BACK, 32'hdead_beef, 3'd0);
      issue(cdb_pkg::CMD_PUSH_FRONT, 32'hcafe_f00d, 3'd0);
      issue(cdb_pkg::CMD_READ, '0, 3'd7);
      issue(cdb_pkg::CMD_WRITE, '1, 3'd7);
      issue(cdb_pkg::CMD_WRITE, '0, 3'd0);
      issue(cdb_pkg::CMD_READ, '1, 3'd0);
      issue(cdb_pkg::CMD_POP_FRONT, '0, 3'd0);
      issue(cdb_pkg::CMD_READ, '0, 3'd7);
      issue(cdb_pkg::CMD_POP_BACK, '0, 3'd0);
   endtask

   task automatic run_random(int n);
      int  r;
      int  phase_left;
      bit  filling;
      int  push_w;
      int  pop_w;
      logic [2:0]                 cmd;
      logic [2:0]                 pos;
      logic [cdb_pkg::DATA_W-1:0] data;
      phase_left = 0;
      filling = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (phase_left == 0) begin
            filling = $urandom_range(0, 1);
            phase_left = $urandom_range(4, 30);
         end
         phase_left--;
         push_w = filling ? 45 : 20;
         pop_w  = filling ? 20 : 45;
         r = $urandom_range(0, 99);
         if (r < push_w) begin
            cmd = $urandom_range(0, 1) ? cdb_pkg::CMD_PUSH_FRONT : cdb_pkg::CMD_PUSH_BACK;
         end else if (r < push_w + pop_w) begin
            cmd = $urandom_range(0, 1) ? cdb_pkg::CMD_POP_FRONT : cdb_pkg::CMD_POP_BACK;
         end else if (r < push_w + pop_w + 15) begin
            cmd = cdb_pkg::CMD_READ;
         end else if (r < push_w + pop_w + 30) begin
            cmd = cdb_pkg::CMD_WRITE;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
         end
         if (level > 0 && $urandom_range(0, 9) < 8) begin
            pos = 3'($urandom_range(0, level - 1));
         end else begin
            pos = 3'($urandom_range(0, 7));
         end
         case ($urandom_range(0, 9))
            0: data = '0;
            1: data = '1;
            default: data = $urandom;
         endcase
         issue(cmd, data, pos);
      end
   endtask

   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      level       = 0;
      send_quiet  = 0;
      squeeze     = 1'b0;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      squeeze = 1'b1;
      run_random(RANDOM_REQUESTS);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("** circular_deque_buffer: PASSED **");
      end else begin
         $display("** circular_deque_buffer: FAILED **");
      end
      $finish;
   end

   // response side stall pattern; one long hold-off lets the block back up
   initial begin
      int n;
      int quiet_left;
      quiet_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            n = HOLD_OFF_CYCLES;
         end else if (quiet_left > 0) begin
            quiet_left--;
            n = 0;
         end else begin
            if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(20, 80);
            n = idle_len();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_payload);
      end
   end

   // no handshake on either channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("** circular_deque_buffer: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

[filelist.f]
design/cdb_pkg.sv
design/cdb_ctrl.sv
design/cdb_dpath.sv
design/circular_deque_buffer.sv
sim/circular_deque_buffer_test.sv
